@@ sv/afk_pkg.sv @@
`timescale 1ns / 1ps

package afk_pkg;

    // fixed-point formats
    localparam int ANGLE_FRAC_BITS  = 13;
    localparam int LENGTH_FRAC_BITS = 8;
    localparam int CORDIC_FRAC      = 16;
    localparam int ANGLE_SHIFT      = CORDIC_FRAC - ANGLE_FRAC_BITS;

    // pi in the angle format, rounded from a 32 fraction bit constant
    localparam longint PI_Q32   = 64'sd13493037705;
    localparam longint PI_Q_L   = (PI_Q32 + (64'sd1 << (31 - ANGLE_FRAC_BITS)))
                                  >>> (32 - ANGLE_FRAC_BITS);
    localparam int     PI_Q     = int'(PI_Q_L);
    localparam int     TWO_PI_Q = 2 * PI_Q;

    // cordic constants in q16
    localparam int PI_16        = 205887;
    localparam int HALF_PI_16   = 102944;
    localparam int CORDIC_GAIN  = 39797;
    localparam int CORDIC_STEPS = 16;
    localparam int DW           = 20;

    // output scaling
    localparam int FRAC_Y  = LENGTH_FRAC_BITS + 16;
    localparam int FRAC_XZ = LENGTH_FRAC_BITS + 32;
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN_MAG = 131072;

    // register indexes
    localparam logic [2:0] REG_LINK1       = 3'd0;
    localparam logic [2:0] REG_LINK2       = 3'd1;
    localparam logic [2:0] REG_LINK3       = 3'd2;
    localparam logic [2:0] REG_BASE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SHOULDER    = 3'd4;
    localparam logic [2:0] REG_START_BASE  = 3'd5;
    localparam logic [2:0] REG_START_ELBOW = 3'd6;
    localparam logic [2:0] REG_START_WRIST = 3'd7;

    // register reset values
    localparam logic [15:0] RST_LINK1       = 16'd1534;
    localparam logic [15:0] RST_LINK2       = 16'd2754;
    localparam logic [15:0] RST_LINK3       = 16'd4795;
    localparam logic [15:0] RST_BASE_HEIGHT = 16'd1075;
    localparam logic [15:0] RST_SHOULDER    = 16'd4779;
    localparam logic [15:0] RST_BASE_ANGLE  = 16'd0;
    localparam logic [15:0] RST_ELBOW_ANGLE = 16'd1532;
    localparam logic [15:0] RST_WRIST_ANGLE = 16'd1540;

    // angle tags carried through the chain
    localparam logic [1:0] TAG_BASE     = 2'd0;
    localparam logic [1:0] TAG_SHOULDER = 2'd1;
    localparam logic [1:0] TAG_ELBOW    = 2'd2;
    localparam logic [1:0] TAG_WRIST    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_WAIT,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } t_cord;

    typedef struct packed {
        logic       valid;
        logic [1:0] tag;
        logic       neg;
    } t_tok;

    // arctangent table in q16
    function automatic logic signed [DW-1:0] atan_at(input int i);
        logic signed [DW-1:0] v;
        case (i)
            0:       v = 20'sd51472;
            1:       v = 20'sd30386;
            2:       v = 20'sd16055;
            3:       v = 20'sd8150;
            4:       v = 20'sd4091;
            5:       v = 20'sd2047;
            6:       v = 20'sd1024;
            7:       v = 20'sd512;
            8:       v = 20'sd256;
            9:       v = 20'sd128;
            10:      v = 20'sd64;
            11:      v = 20'sd32;
            12:      v = 20'sd16;
            13:      v = 20'sd8;
            14:      v = 20'sd4;
            15:      v = 20'sd2;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

    // wrap into [-pi, pi); input within one turn of the range
    function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] a);
        logic signed [17:0] t;
        t = a + 18'(PI_Q);
        if (t < 0) begin
            t = t + 18'(TWO_PI_Q);
        end else if (t >= 18'(TWO_PI_Q)) begin
            t = t - 18'(TWO_PI_Q);
        end
        return 16'(t - 18'(PI_Q));
    endfunction

endpackage

@@ sv/afk_cell.sv @@
`timescale 1ns / 1ps

module afk_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  afk_pkg::t_tok  i_tok,
    input  afk_pkg::t_cord i_cord,
    output afk_pkg::t_tok  o_tok,
    output afk_pkg::t_cord o_cord
);

    afk_pkg::t_tok  r_tok;
    afk_pkg::t_cord r_cord;
    afk_pkg::t_cord n_cord;

    // one micro-rotation, direction from the residual angle sign
    always_comb begin
        if (i_cord.z >= 0) begin
            n_cord.x = i_cord.x - (i_cord.y >>> STEP);
            n_cord.y = i_cord.y + (i_cord.x >>> STEP);
            n_cord.z = i_cord.z - afk_pkg::atan_at(STEP);
        end else begin
            n_cord.x = i_cord.x + (i_cord.y >>> STEP);
            n_cord.y = i_cord.y - (i_cord.x >>> STEP);
            n_cord.z = i_cord.z + afk_pkg::atan_at(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cord <= n_cord;
    end

    assign o_tok  = r_tok;
    assign o_cord = r_cord;

endmodule

@@ sv/afk_chain.sv @@
`timescale 1ns / 1ps

module afk_chain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  afk_pkg::t_tok  i_tok,
    input  afk_pkg::t_cord i_cord,
    output afk_pkg::t_tok  o_tok,
    output afk_pkg::t_cord o_cord
);

    afk_pkg::t_tok  w_tok  [0:afk_pkg::CORDIC_STEPS];
    afk_pkg::t_cord w_cord [0:afk_pkg::CORDIC_STEPS];

    assign w_tok[0]  = i_tok;
    assign w_cord[0] = i_cord;

    // row of rotation cells, one shift amount each
    for (genvar g = 0; g < afk_pkg::CORDIC_STEPS; g++) begin : g_cell
        afk_cell #(
            .STEP(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[g]),
            .i_cord (w_cord[g]),
            .o_tok  (w_tok[g+1]),
            .o_cord (w_cord[g+1])
        );
    end

    assign o_tok  = w_tok[afk_pkg::CORDIC_STEPS];
    assign o_cord = w_cord[afk_pkg::CORDIC_STEPS];

endmodule

@@ sv/afk_post.sv @@
`timescale 1ns / 1ps

module afk_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_link1,
    input  logic [15:0]        i_link2,
    input  logic [15:0]        i_link3,
    input  logic signed [15:0] i_base_height,
    input  afk_pkg::t_tok       i_tok,
    input  afk_pkg::t_cord      i_cord,
    output logic               o_done,
    output logic signed [17:0] o_pos_x,
    output logic signed [17:0] o_pos_y,
    output logic signed [17:0] o_pos_z
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_LO   = 3'd1;
    localparam logic [2:0] M_HI   = 3'd2;
    localparam logic [2:0] M_SUM  = 3'd3;
    localparam logic [2:0] M_ABS  = 3'd4;
    localparam logic [2:0] M_MUL  = 3'd5;
    localparam logic [2:0] M_SAT  = 3'd6;

    logic signed [19:0] w_sin20, w_cos20;
    logic signed [17:0] w_sin, w_cos;
    logic signed [16:0] w_len;

    logic               r_pv;
    logic [1:0]         r_ptag;
    logic signed [34:0] r_ps, r_pc;
    logic signed [17:0] r_sb, r_cb;
    logic signed [37:0] r_acc_y, r_acc_d;
    logic [2:0]         r_mstep;
    logic               r_done;

    logic signed [37:0] r_lo_x, r_lo_z;
    logic signed [36:0] r_hi_x, r_hi_z;
    logic signed [55:0] r_val [3];
    logic               r_neg [3];
    logic [55:0]        r_mag [3];
    logic [63:0]        r_ma  [3];
    logic [63:0]        r_mb  [3];
    logic signed [17:0] r_res [3];

    logic signed [19:0] w_lo;
    logic signed [18:0] w_hi;

    // undo the quadrant fold on the chain output
    assign w_sin20 = i_tok.neg ? -i_cord.y : i_cord.y;
    assign w_cos20 = i_tok.neg ? -i_cord.x : i_cord.x;
    assign w_sin   = 18'(w_sin20);
    assign w_cos   = 18'(w_cos20);

    // link length for the arriving joint
    always_comb begin
        case (i_tok.tag)
            afk_pkg::TAG_SHOULDER: w_len = {1'b0, i_link1};
            afk_pkg::TAG_ELBOW:    w_len = {1'b0, i_link2};
            default:               w_len = {1'b0, i_link3};
        endcase
    end

    // reach split into partial-product halves
    assign w_lo = {1'b0, r_acc_d[18:0]};
    assign w_hi = r_acc_d[37:19];

    // control: product valid, post step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_mstep <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_pv   <= i_tok.valid && (i_tok.tag != afk_pkg::TAG_BASE);
            r_done <= (r_mstep == M_SAT);
            if (r_pv && (r_ptag == afk_pkg::TAG_WRIST)) begin
                r_mstep <= M_LO;
            end else if (r_mstep == M_SAT) begin
                r_mstep <= M_IDLE;
            end else if (r_mstep != M_IDLE) begin
                r_mstep <= r_mstep + 3'd1;
            end
        end
    end

    // joint products and sums
    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_ptag <= i_tok.tag;
            if (i_tok.tag == afk_pkg::TAG_BASE) begin
                r_sb <= w_sin;
                r_cb <= w_cos;
            end else begin
                r_ps <= w_len * w_sin;
                r_pc <= w_len * w_cos;
            end
        end
        if (i_start) begin
            r_acc_y <= 38'(i_base_height) <<< 16;
            r_acc_d <= '0;
        end else if (r_pv) begin
            r_acc_y <= r_acc_y + 38'(r_ps);
            if (r_ptag == afk_pkg::TAG_ELBOW) begin
                r_acc_d <= r_acc_d - 38'(r_pc);
            end else begin
                r_acc_d <= r_acc_d + 38'(r_pc);
            end
        end
    end

    // base rotation, scaling to hundredths, rounding and saturation
    always_ff @(posedge i_clk) begin
        case (r_mstep)
            M_LO: begin
                r_lo_x <= w_lo * r_sb;
                r_lo_z <= w_lo * r_cb;
            end
            M_HI: begin
                r_hi_x <= w_hi * r_sb;
                r_hi_z <= w_hi * r_cb;
            end
            M_SUM: begin
                r_val[0] <= (56'(r_hi_x) <<< 19) + 56'(r_lo_x);
                r_val[1] <= 56'(r_acc_y);
                r_val[2] <= (56'(r_hi_z) <<< 19) + 56'(r_lo_z);
            end
            M_ABS: begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= r_val[k] < 0;
                    r_mag[k] <= (r_val[k] < 0) ? 56'(-r_val[k]) : 56'(r_val[k]);
                end
            end
            M_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_ma[k] <= (64'(r_mag[k]) << 6) + (64'(r_mag[k]) << 5);
                    if (k == 1) begin
                        r_mb[k] <= (64'(r_mag[k]) << 2) + (64'd1 << (afk_pkg::FRAC_Y - 1));
                    end else begin
                        r_mb[k] <= (64'(r_mag[k]) << 2) + (64'd1 << (afk_pkg::FRAC_XZ - 1));
                    end
                end
            end
            M_SAT: begin
                for (int k = 0; k < 3; k++) begin
                    logic [63:0] q;
                    if (k == 1) begin
                        q = (r_ma[k] + r_mb[k]) >> afk_pkg::FRAC_Y;
                    end else begin
                        q = (r_ma[k] + r_mb[k]) >> afk_pkg::FRAC_XZ;
                    end
                    if (r_neg[k]) begin
                        if (q > 64'(afk_pkg::OUT_MIN_MAG)) begin
                            r_res[k] <= 18'(-afk_pkg::OUT_MIN_MAG);
                        end else begin
                            r_res[k] <= 18'(64'd0 - q);
                        end
                    end else begin
                        if (q > 64'(afk_pkg::OUT_MAX)) begin
                            r_res[k] <= 18'(afk_pkg::OUT_MAX);
                        end else begin
                            r_res[k] <= 18'(q);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_pos_x = r_res[0];
    assign o_pos_y = r_res[1];
    assign o_pos_z = r_res[2];

endmodule

@@ sv/arm_forward_kinematics.sv @@
`timescale 1ns / 1ps

// Three-joint arm forward kinematics. Each input word adds three angle
// increments to the stored base, elbow and wrist angles and returns the tip
// position (x, y, z) in hundredths of a length unit. One item is in work at a
// time: the base, shoulder, elbow and wrist angles are fed one after another
// into a 16-cell CORDIC chain and pass through the chain, then come link
// products and sums, and then base rotation, scaling and rounding. The result
// sits in an output register, so a new word is taken while the last result
// waits. Configuration writes are taken only while no word is in work and no
// input word is offered.
module arm_forward_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_delta_base,
    input  logic signed [15:0] i_delta_elbow,
    input  logic signed [15:0] i_delta_wrist,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_pos_x,
    output logic signed [17:0] o_pos_y,
    output logic signed [17:0] o_pos_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    afk_pkg::t_state r_state, n_state;

    logic [15:0]        r_link1, r_link2, r_link3;
    logic signed [15:0] r_base_height, r_shoulder;
    logic signed [15:0] r_ang_b, r_ang_e, r_ang_w;
    logic [1:0]         r_feed;
    logic               r_out_valid;
    logic signed [17:0] r_pos_x, r_pos_y, r_pos_z;

    logic               w_in_acc, w_cfg_acc, w_free, w_load, w_feed_en;
    logic signed [15:0] w_ang;
    logic signed [19:0] w_z0, w_z;
    logic               w_neg;
    afk_pkg::t_tok       w_tok_in, w_tok_out;
    afk_pkg::t_cord      w_cord_in, w_cord_out;
    logic               w_done;
    logic signed [17:0] w_px, w_py, w_pz;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;
    assign w_free    = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            afk_pkg::S_IDLE: if (w_in_acc) n_state = afk_pkg::S_FEED;
            afk_pkg::S_FEED: if (r_feed == afk_pkg::TAG_WRIST) n_state = afk_pkg::S_WAIT;
            afk_pkg::S_WAIT: begin
                if (w_done) n_state = w_free ? afk_pkg::S_IDLE : afk_pkg::S_HOLD;
            end
            afk_pkg::S_HOLD: if (w_free) n_state = afk_pkg::S_IDLE;
            default:         n_state = afk_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_feed_en  = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            afk_pkg::S_IDLE: o_in_stall = 1'b0;
            afk_pkg::S_FEED: w_feed_en = 1'b1;
            afk_pkg::S_WAIT: w_load = w_done && w_free;
            afk_pkg::S_HOLD: w_load = w_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= afk_pkg::S_IDLE;
            r_feed  <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_feed <= '0;
            end else if (w_feed_en) begin
                r_feed <= r_feed + 2'd1;
            end
        end
    end

    // configuration registers and joint angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link1       <= afk_pkg::RST_LINK1;
            r_link2       <= afk_pkg::RST_LINK2;
            r_link3       <= afk_pkg::RST_LINK3;
            r_base_height <= afk_pkg::RST_BASE_HEIGHT;
            r_shoulder    <= afk_pkg::RST_SHOULDER;
            r_ang_b       <= afk_pkg::RST_BASE_ANGLE;
            r_ang_e       <= afk_pkg::RST_ELBOW_ANGLE;
            r_ang_w       <= afk_pkg::RST_WRIST_ANGLE;
        end else if (w_in_acc) begin
            r_ang_b <= afk_pkg::wrap_angle(18'(r_ang_b) + 18'(i_delta_base));
            r_ang_e <= afk_pkg::wrap_angle(18'(r_ang_e) + 18'(i_delta_elbow));
            r_ang_w <= afk_pkg::wrap_angle(18'(r_ang_w) + 18'(i_delta_wrist));
        end else if (w_cfg_acc) begin
            case (i_cfg_index)
                afk_pkg::REG_LINK1:       r_link1 <= i_cfg_data;
                afk_pkg::REG_LINK2:       r_link2 <= i_cfg_data;
                afk_pkg::REG_LINK3:       r_link3 <= i_cfg_data;
                afk_pkg::REG_BASE_HEIGHT: r_base_height <= i_cfg_data;
                afk_pkg::REG_SHOULDER:    r_shoulder <= i_cfg_data;
                afk_pkg::REG_START_BASE:
                    r_ang_b <= afk_pkg::wrap_angle(18'($signed(i_cfg_data)));
                afk_pkg::REG_START_ELBOW:
                    r_ang_e <= afk_pkg::wrap_angle(18'($signed(i_cfg_data)));
                afk_pkg::REG_START_WRIST:
                    r_ang_w <= afk_pkg::wrap_angle(18'($signed(i_cfg_data)));
                default: begin
                end
            endcase
        end
    end

    // angle feed: pick, rescale to q16, fold into the right half plane
    always_comb begin
        case (r_feed)
            afk_pkg::TAG_BASE:     w_ang = r_ang_b;
            afk_pkg::TAG_SHOULDER: w_ang = afk_pkg::wrap_angle(18'(r_shoulder));
            afk_pkg::TAG_ELBOW:    w_ang = r_ang_e;
            default:               w_ang = r_ang_w;
        endcase
        w_z0  = 20'(w_ang) <<< afk_pkg::ANGLE_SHIFT;
        w_neg = 1'b0;
        w_z   = w_z0;
        if (w_z0 > 20'(afk_pkg::HALF_PI_16)) begin
            w_z   = w_z0 - 20'(afk_pkg::PI_16);
            w_neg = 1'b1;
        end else if (w_z0 < -20'(afk_pkg::HALF_PI_16)) begin
            w_z   = w_z0 + 20'(afk_pkg::PI_16);
            w_neg = 1'b1;
        end
    end

    assign w_tok_in.valid = w_feed_en;
    assign w_tok_in.tag   = r_feed;
    assign w_tok_in.neg   = w_neg;
    assign w_cord_in.x    = 20'(afk_pkg::CORDIC_GAIN);
    assign w_cord_in.y    = '0;
    assign w_cord_in.z    = w_z;

    afk_chain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (w_tok_in),
        .i_cord (w_cord_in),
        .o_tok  (w_tok_out),
        .o_cord (w_cord_out)
    );

    afk_post u_post (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_in_acc),
        .i_link1      (r_link1),
        .i_link2      (r_link2),
        .i_link3      (r_link3),
        .i_base_height(r_base_height),
        .i_tok        (w_tok_out),
        .i_cord       (w_cord_out),
        .o_done       (w_done),
        .o_pos_x      (w_px),
        .o_pos_y      (w_py),
        .o_pos_z      (w_pz)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pos_x <= w_px;
            r_pos_y <= w_py;
            r_pos_z <= w_pz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_pos_z     = r_pos_z;

    // writes only between words, never beside an offered input word
    assign o_cfg_ready = (r_state == afk_pkg::S_IDLE) && !i_in_valid;

endmodule

@@ sv/afk_checker.sv @@
`timescale 1ns / 1ps

module afk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [15:0] i_delta_base,
    input logic signed [15:0] i_delta_elbow,
    input logic signed [15:0] i_delta_wrist,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [17:0] o_pos_x,
    input logic signed [17:0] o_pos_y,
    input logic signed [17:0] o_pos_z,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [2:0]         i_cfg_index,
    input logic [15:0]        i_cfg_data
);

    // an accepted word keeps the input side closed while it is in work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_pos_z)))
        else $error("stalled result changed");

    // a new result only comes from a word in work
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a word in work");

endmodule

bind arm_forward_kinematics afk_checker u_afk_checker (.*);

@@ dv/arm_forward_kinematics_tb.sv @@
`timescale 1ns / 1ps

module arm_forward_kinematics_tb;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
    } t_tip;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_delta_base;
    logic signed [15:0] i_delta_elbow;
    logic signed [15:0] i_delta_wrist;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [17:0] o_pos_x;
    logic signed [17:0] o_pos_y;
    logic signed [17:0] o_pos_z;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    // predictor copy of registers and joint angles
    longint len1, len2, len3, height, shoulder;
    longint ang_base, ang_elbow, ang_wrist;

    t_tip   tip_queue[$];
    int     errors;
    bit     idle_on;
    int     hold_len;
    int     quiet_cycles;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LATENCY        = 40;

    arm_forward_kinematics DUT (.*);

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic longint wrap_q(input longint a);
        longint m;
        longint r;
        m = 2 * longint'(afk_pkg::PI_Q);
        r = (a + longint'(afk_pkg::PI_Q)) % m;
        if (r < 0) begin
            r = r + m;
        end
        return r - longint'(afk_pkg::PI_Q);
    endfunction

    function automatic void sin_cos(input longint a, output longint s, output longint c);
        longint atan_q16[16];
        longint z, x, y, t;
        bit     neg;
        atan_q16 = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2};
        z = wrap_q(a);
        x = afk_pkg::CORDIC_GAIN;
        y = 0;
        neg = 1'b0;
        // rescale angle to q16
        if (afk_pkg::ANGLE_FRAC_BITS > 16) begin
            z = (z + (64'sd1 <<< (afk_pkg::ANGLE_FRAC_BITS - 17)))
                >>> (afk_pkg::ANGLE_FRAC_BITS - 16);
        end else if (afk_pkg::ANGLE_FRAC_BITS < 16) begin
            z = z * (64'sd1 <<< (16 - afk_pkg::ANGLE_FRAC_BITS));
        end
        // fold into the right half plane
        if (z > afk_pkg::HALF_PI_16) begin
            z = z - afk_pkg::PI_16;
            neg = 1'b1;
        end else if (z < -afk_pkg::HALF_PI_16) begin
            z = z + afk_pkg::PI_16;
            neg = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_q16[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_q16[i];
            end
            x = t;
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function automatic logic signed [17:0] to_centi(input longint v, input int f);
        longint unsigned mag;
        longint          r;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        mag = (mag * 100 + (64'd1 << (f - 1))) >> f;
        if (v < 0) begin
            r = (mag > afk_pkg::OUT_MIN_MAG) ? -longint'(afk_pkg::OUT_MIN_MAG)
                                             : -longint'(mag);
        end else begin
            r = (mag > afk_pkg::OUT_MAX) ? longint'(afk_pkg::OUT_MAX) : longint'(mag);
        end
        return 18'(r);
    endfunction

    function automatic t_tip predict_tip(input logic signed [15:0] db,
                                         input logic signed [15:0] de,
                                         input logic signed [15:0] dw);
        longint sb, cb, ss, cs, se, ce, sw, cw, y, d1;
        t_tip   tip;
        ang_base  = wrap_q(ang_base + longint'(db));
        ang_elbow = wrap_q(ang_elbow + longint'(de));
        ang_wrist = wrap_q(ang_wrist + longint'(dw));
        sin_cos(ang_base, sb, cb);
        sin_cos(shoulder, ss, cs);
        sin_cos(ang_elbow, se, ce);
        sin_cos(ang_wrist, sw, cw);
        y  = height * 65536 + len1 * ss + len2 * se + len3 * sw;
        d1 = len3 * cw - len2 * ce + len1 * cs;
        tip.x = to_centi(d1 * sb, afk_pkg::FRAC_XZ);
        tip.y = to_centi(y, afk_pkg::FRAC_Y);
        tip.z = to_centi(d1 * cb, afk_pkg::FRAC_XZ);
        return tip;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_tip want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tip_queue.size() == 0) begin
                $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                         o_pos_x, o_pos_y, o_pos_z);
                errors++;
            end else begin
                want = tip_queue.pop_front();
                if (o_pos_x !== want.x) begin
                    $display("%0t: pos_x expected %0d actual %0d", $time, want.x, o_pos_x);
                    errors++;
                end
                if (o_pos_y !== want.y) begin
                    $display("%0t: pos_y expected %0d actual %0d", $time, want.y, o_pos_y);
                    errors++;
                end
                if (o_pos_z !== want.z) begin
                    $display("%0t: pos_z expected %0d actual %0d", $time, want.z, o_pos_z);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any input, output or configuration handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver stall: random bursts and requested long hold-offs
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_out_stall = 1'b1;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
                i_out_stall = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic send_word(input logic [15:0] db, input logic [15:0] de,
                             input logic [15:0] dw);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_delta_base  = db;
        i_delta_elbow = de;
        i_delta_wrist = dw;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tip_queue.push_back(predict_tip(db, de, dw));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tip_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            afk_pkg::REG_LINK1:       len1 = longint'(val);
            afk_pkg::REG_LINK2:       len2 = longint'(val);
            afk_pkg::REG_LINK3:       len3 = longint'(val);
            afk_pkg::REG_BASE_HEIGHT: height = longint'($signed(val));
            afk_pkg::REG_SHOULDER:    shoulder = longint'($signed(val));
            afk_pkg::REG_START_BASE:  ang_base = wrap_q(longint'($signed(val)));
            afk_pkg::REG_START_ELBOW: ang_elbow = wrap_q(longint'($signed(val)));
            afk_pkg::REG_START_WRIST: ang_wrist = wrap_q(longint'($signed(val)));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h8000;
            3:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_delta();
        case ($urandom_range(0, 7))
            0:       return pick_value();
            1, 2:    return 16'($signed(10'($urandom)));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_reset_values();
        send_word(16'h0000, 16'h0000, 16'h0000);
        send_word(16'h0001, 16'hffff, 16'h0100);
        send_word(16'h1000, 16'hf000, 16'h0800);
    endtask

    task automatic test_delta_extremes();
        send_word(16'h7fff, 16'h7fff, 16'h7fff);
        send_word(16'h8000, 16'h8000, 16'h8000);
        send_word(16'h8000, 16'h7fff, 16'h0000);
        send_word(16'hffff, 16'h0001, 16'h8000);
        send_word(16'h5555, 16'haaaa, 16'h3243);
        send_word(16'haaaa, 16'h5555, 16'hcdbc);
    endtask

    task automatic test_register_extremes();
        // out-of-range start angles wrap on load, the shoulder angle when it is fed
        write_reg(afk_pkg::REG_SHOULDER, 16'h7fff);
        write_reg(afk_pkg::REG_START_BASE, 16'h8000);
        write_reg(afk_pkg::REG_START_ELBOW, 16'h7fff);
        write_reg(afk_pkg::REG_START_WRIST, 16'h6488);
        send_word(16'h0000, 16'h0000, 16'h0000);
        write_reg(afk_pkg::REG_SHOULDER, 16'h8000);
        send_word(16'h0001, 16'h0000, 16'hffff);
        // zero links
        write_reg(afk_pkg::REG_LINK1, 16'h0000);
        write_reg(afk_pkg::REG_LINK2, 16'h0000);
        write_reg(afk_pkg::REG_LINK3, 16'h0000);
        write_reg(afk_pkg::REG_BASE_HEIGHT, 16'h8000);
        send_word(16'h0100, 16'h0200, 16'h0300);
        // saturation with full links and height
        write_reg(afk_pkg::REG_LINK1, 16'hffff);
        write_reg(afk_pkg::REG_LINK2, 16'hffff);
        write_reg(afk_pkg::REG_LINK3, 16'hffff);
        write_reg(afk_pkg::REG_BASE_HEIGHT, 16'h7fff);
        write_reg(afk_pkg::REG_SHOULDER, 16'h3244);
        send_word(16'h0000, 16'h0000, 16'h0000);
        send_word(16'h1922, 16'h6488, 16'h9b78);
        write_reg(afk_pkg::REG_SHOULDER, 16'hcdbc);
        write_reg(afk_pkg::REG_BASE_HEIGHT, 16'h8000);
        send_word(16'he6de, 16'h0000, 16'h0000);
    endtask

    task automatic test_backpressure();
        drain();
        hold_len = 300;
        repeat (12) send_word(pick_delta(), pick_delta(), pick_delta());
        drain();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 300 == 0) begin
                for (int r = 0; r < 8; r++) begin
                    write_reg(3'(r), pick_value());
                end
            end
            send_word(pick_delta(), pick_delta(), pick_delta());
        end
    endtask

    initial begin
        errors        = 0;
        idle_on       = 1'b0;
        hold_len      = 0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_delta_base  = '0;
        i_delta_elbow = '0;
        i_delta_wrist = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        len1      = afk_pkg::RST_LINK1;
        len2      = afk_pkg::RST_LINK2;
        len3      = afk_pkg::RST_LINK3;
        height    = longint'($signed(afk_pkg::RST_BASE_HEIGHT));
        shoulder  = longint'($signed(afk_pkg::RST_SHOULDER));
        ang_base  = wrap_q(longint'($signed(afk_pkg::RST_BASE_ANGLE)));
        ang_elbow = wrap_q(longint'($signed(afk_pkg::RST_ELBOW_ANGLE)));
        ang_wrist = wrap_q(longint'($signed(afk_pkg::RST_WRIST_ANGLE)));
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_delta_extremes();
        test_register_extremes();
        idle_on = 1'b1;
        test_random(1500);
        test_backpressure();
        idle_on = 1'b0;
        test_random(300);

        drain();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/afk_pkg.sv
sv/afk_cell.sv
sv/afk_chain.sv
sv/afk_post.sv
sv/arm_forward_kinematics.sv
sv/afk_checker.sv
dv/arm_forward_kinematics_tb.sv
